[hdl/bsrt_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bsrt_pkg
// shared types, codes and size helper for the banked symbol range table
// ---------------------------------------------------------------------------
package bsrt_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int HIT_INDEX_W = 10;

	localparam logic [15:0] LOW_WINDOW  = 16'h4000;
	localparam logic [15:0] HIGH_WINDOW = 16'h8000;
	localparam logic [15:0] TOP_ADDRESS = 16'hFFFF;

	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [HIT_INDEX_W-1:0] hit_idx_t;

	typedef enum logic [1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_FINISH = 2'd2,
		REQ_LOOKUP = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_READY = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch the accepted item
		logic exec;      // run clear, append or finish, set up a lookup
		logic scan;      // step the lookup scan
		logic out_load;  // move the staged result to the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic lookup_go; // lookup on a ready, non-empty table
		logic match;     // scanned entry covers the probe
		logic last;      // scanned entry is the last stored one
	} stat_t;

	// size of the previous entry once the next start is known
	function automatic logic [15:0] size_before(input logic [15:0] pbank,
		input logic [15:0] pstart, input logic [15:0] nbank, input logic [15:0] nstart);
		logic [15:0] lim;
		logic [15:0] diff;
		lim  = (nstart < LOW_WINDOW) ? nstart : LOW_WINDOW;
		diff = nstart - pstart;
		if (pbank == 16'd0 && pstart < LOW_WINDOW) begin
			diff = lim - pstart;
		end else if (pstart >= LOW_WINDOW && pstart < HIGH_WINDOW) begin
			if (pbank != nbank) begin
				diff = HIGH_WINDOW - pstart;
			end
		end
		return diff;
	endfunction

endpackage
`default_nettype wire

[hdl/bsrt_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bsrt_ctrl
// sequencer: accept, execute, scan on lookup, hand the result to the output
// ---------------------------------------------------------------------------
module bsrt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire bsrt_pkg::stat_t stat,
	output bsrt_pkg::cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == S_IDLE) && in_valid;
		cmd.exec     = (state_q == S_EXEC);
		cmd.scan     = (state_q == S_SCAN);
		cmd.out_load = (state_q == S_RESP) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= stat.lookup_go ? S_SCAN : S_RESP;
				end
				S_SCAN: begin
					if (stat.match || stat.last) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[hdl/bsrt_dpath.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bsrt_dpath
// entry memories, count and ready flags, scan compare, result registers
// ---------------------------------------------------------------------------
module bsrt_dpath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire bsrt_pkg::cmd_t  cmd,
	output bsrt_pkg::stat_t      stat,
	input  wire logic [1:0]      req_type,
	input  wire logic [15:0]     item_bank,
	input  wire logic [15:0]     item_address,
	output logic [1:0]           status,
	output logic                 hit,
	output logic [bsrt_pkg::HIT_INDEX_W-1:0] hit_index,
	output logic [15:0]          hit_start,
	output logic [15:0]          hit_size
);

	// latched item
	logic [1:0]  req_q;
	logic [15:0] key_bank_q;
	logic [15:0] key_addr_q;

	// table state
	bsrt_pkg::cnt_t count_q;
	logic           ready_q;
	logic [15:0]    last_bank_q;
	logic [15:0]    last_start_q;

	// memories: bank/start at one entry, size at another
	logic [31:0] bs_mem [bsrt_pkg::MAX_ENTRIES];
	logic [15:0] sz_mem [bsrt_pkg::MAX_ENTRIES];

	// scan
	bsrt_pkg::cnt_t rd_addr_q;
	logic           rd_valid_s1;
	bsrt_pkg::idx_t rd_idx_s1;
	logic [31:0]    bs_rd_s1;
	logic [15:0]    sz_rd_s1;

	// staged result
	logic [1:0]          res_status_q;
	logic                res_hit_q;
	bsrt_pkg::hit_idx_t  res_idx_q;
	logic [15:0]         res_start_q;
	logic [15:0]         res_size_q;

	// output register
	logic [1:0]          out_status_q;
	logic                out_hit_q;
	bsrt_pkg::hit_idx_t  out_idx_q;
	logic [15:0]         out_start_q;
	logic [15:0]         out_size_q;

	logic           is_full;
	logic           do_append;
	logic           do_finish;
	bsrt_pkg::idx_t wr_idx;
	bsrt_pkg::idx_t prev_idx;
	logic           sz_we;
	logic [15:0]    sz_wdata;
	logic           issue;
	logic [16:0]    scan_end;
	logic           match;

	assign is_full   = (count_q == bsrt_pkg::cnt_t'(bsrt_pkg::MAX_ENTRIES));
	assign do_append = cmd.exec && (req_q == bsrt_pkg::REQ_APPEND) && !is_full;
	assign do_finish = cmd.exec && (req_q == bsrt_pkg::REQ_FINISH);
	assign wr_idx    = count_q[bsrt_pkg::IDX_W-1:0];
	assign prev_idx  = bsrt_pkg::idx_t'(count_q - bsrt_pkg::cnt_t'(1));

	// size fix of the previous entry, on append or finish
	assign sz_we    = (do_append || do_finish) && (count_q != '0);
	assign sz_wdata = do_finish ? (bsrt_pkg::TOP_ADDRESS - last_start_q)
	                            : bsrt_pkg::size_before(last_bank_q, last_start_q,
	                                                    key_bank_q, key_addr_q);

	assign issue    = cmd.scan && (rd_addr_q < count_q);
	assign scan_end = {1'b0, bs_rd_s1[15:0]} + {1'b0, sz_rd_s1};
	assign match    = rd_valid_s1 && (bs_rd_s1[31:16] == key_bank_q)
	                  && (bs_rd_s1[15:0] <= key_addr_q) && (scan_end > {1'b0, key_addr_q});

	always_comb begin
		stat           = '0;
		stat.lookup_go = (req_q == bsrt_pkg::REQ_LOOKUP) && ready_q && (count_q != '0);
		stat.match     = match;
		stat.last      = rd_valid_s1 && (rd_idx_s1 == prev_idx);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q      <= req_type;
			key_bank_q <= item_bank;
			key_addr_q <= item_address;
		end
		if (do_append) begin
			last_bank_q  <= key_bank_q;
			last_start_q <= key_addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ready_q <= 1'b0;
		end else if (cmd.exec) begin
			unique case (req_q)
				bsrt_pkg::REQ_CLEAR: begin
					count_q <= '0;
					ready_q <= 1'b0;
				end
				bsrt_pkg::REQ_APPEND: begin
					if (!is_full) begin
						count_q <= count_q + bsrt_pkg::cnt_t'(1);
						ready_q <= 1'b0;
					end
				end
				bsrt_pkg::REQ_FINISH: ready_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// bank/start memory
	always_ff @(posedge clk) begin
		if (do_append) begin
			bs_mem[wr_idx] <= {key_bank_q, key_addr_q};
		end
		if (issue) begin
			bs_rd_s1 <= bs_mem[rd_addr_q[bsrt_pkg::IDX_W-1:0]];
		end
	end

	// size memory
	always_ff @(posedge clk) begin
		if (sz_we) begin
			sz_mem[prev_idx] <= sz_wdata;
		end
		if (issue) begin
			sz_rd_s1 <= sz_mem[rd_addr_q[bsrt_pkg::IDX_W-1:0]];
		end
	end

	// scan address and read tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q   <= '0;
			rd_valid_s1 <= 1'b0;
		end else if (cmd.exec) begin
			rd_addr_q   <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (issue) begin
				rd_addr_q <= rd_addr_q + bsrt_pkg::cnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_idx_s1 <= rd_addr_q[bsrt_pkg::IDX_W-1:0];
		end
	end

	// staged result
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_hit_q   <= 1'b0;
			res_idx_q   <= '0;
			res_start_q <= '0;
			res_size_q  <= '0;
			if (req_q == bsrt_pkg::REQ_APPEND && is_full) begin
				res_status_q <= bsrt_pkg::ST_FULL;
			end else if (req_q == bsrt_pkg::REQ_LOOKUP && !ready_q) begin
				res_status_q <= bsrt_pkg::ST_NOT_READY;
			end else begin
				res_status_q <= bsrt_pkg::ST_OK;
			end
		end else if (cmd.scan && match) begin
			res_hit_q   <= 1'b1;
			res_idx_q   <= bsrt_pkg::hit_idx_t'(rd_idx_s1);
			res_start_q <= bs_rd_s1[15:0];
			res_size_q  <= sz_rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_hit_q    <= res_hit_q;
			out_idx_q    <= res_idx_q;
			out_start_q  <= res_start_q;
			out_size_q   <= res_size_q;
		end
	end

	assign status    = out_status_q;
	assign hit       = out_hit_q;
	assign hit_index = out_idx_q;
	assign hit_start = out_start_q;
	assign hit_size  = out_size_q;

endmodule
`default_nettype wire

[hdl/banked_symbol_range_table.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// banked_symbol_range_table
// ordered table of (bank, start, size) entries with in-order append,
// finish and first-match range lookup
// ---------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_ready with req_type, item_bank, item_address;
//   req_type selects clear, append, finish or lookup
//   output channel: out_valid/out_ready with status, hit, hit_index,
//   hit_start, hit_size; exactly one result item per input item, in order
//   sequence: an accepted item is latched, executed into a staging register
//   and then moved to the output register; a lookup on a ready, non-empty
//   table first scans entries from index 0 at one entry per cycle through the
//   single read port of the entry memories, up to the first match or the last
//   stored entry; flow: one item at a time; the next item is taken only after
//   the result of the last one has moved to the output register
//   stall: the result sits in the output register while out_ready is low; the
//   next item is still accepted and runs, and its result waits in a staging
//   register until the output register is free
//   reset: arst_n empties the table and clears the ready flag; the entry
//   memories are not cleared, only entries below the count are ever read
// ---------------------------------------------------------------------------
module banked_symbol_range_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [15:0] item_bank,
	input  wire logic [15:0] item_address,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic             hit,
	output logic [bsrt_pkg::HIT_INDEX_W-1:0] hit_index,
	output logic [15:0]      hit_start,
	output logic [15:0]      hit_size
);

	bsrt_pkg::cmd_t  cmd;
	bsrt_pkg::stat_t stat;

	// sequencer
	bsrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// table storage, scan compare and result registers
	bsrt_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req_type     (req_type),
		.item_bank    (item_bank),
		.item_address (item_address),
		.status       (status),
		.hit          (hit),
		.hit_index    (hit_index),
		.hit_start    (hit_start),
		.hit_size     (hit_size)
	);

endmodule
`default_nettype wire
